// File: sv/spwm_pkg.sv
package spwm_pkg;

	localparam int TABLE_STEPS_DEF = 32;

	localparam int SAMPLE_W = 10;
	localparam int DUTY_W = 8;
	localparam int AMP_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 32;

	localparam logic [AMP_W-1:0] AMP_MAX = 10'd900;
	localparam logic [AMP_W-1:0] AMP_MIN = 10'd500;

	// Duty is floor(entry * amplitude / 1000), taken as (amplitude * entry * RECIP) >> RECIP_SHIFT.
	localparam int RECIP = 268436;
	localparam int RECIP_SHIFT = 28;
	localparam int SCALED_W = 27;
	localparam int PROD_W = SCALED_W + AMP_W;

	localparam int HALF_POINTS = 16;
	localparam int FULL_POINTS = 32;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_LOW_BATT = 2'd1,
		FAULT_TEMP = 2'd2
	} fault_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATTERY_LOW = 3'd0,
		REG_FAN_ON = 3'd1,
		REG_FAN_OFF = 3'd2,
		REG_OVER_TEMP = 3'd3,
		REG_OPEN_SENSOR = 3'd4,
		REG_VOLT_LOW = 3'd5,
		REG_VOLT_HIGH = 3'd6
	} reg_idx_t;

	function automatic int half_sine_base(input int idx);
		int v;
		case (idx)
			0: v = 0;
			1: v = 25;
			2: v = 49;
			3: v = 73;
			4: v = 96;
			5: v = 118;
			6: v = 139;
			7: v = 159;
			8: v = 177;
			9: v = 193;
			10: v = 208;
			11: v = 220;
			12: v = 231;
			13: v = 239;
			14: v = 245;
			15: v = 249;
			16: v = 250;
			default: v = 0;
		endcase
		return v;
	endfunction

	// Point q of the mirrored 32-point half sine, premultiplied by the reciprocal of 1000.
	function automatic logic [SCALED_W-1:0] scaled_point(input int q);
		int idx;
		idx = (q <= HALF_POINTS) ? q : FULL_POINTS - q;
		return SCALED_W'(half_sine_base(idx) * RECIP);
	endfunction

endpackage

// File: sv/sine_pwm_inverter_controller.sv
// Path: a beat accepted on the input is held in the input register, then its result is registered on the output.
// Throughput: one beat per cycle; the full tick update sits between the input register and
// the result register, and the input stalls only while both hold a beat and the result waits.
// Reset (arst_n low, asynchronous) clears the valid flags and the controller state,
// sets the amplitude to 900 thousandths and loads the limit registers with their defaults.
module sine_pwm_inverter_controller #(
	parameter int TABLE_STEPS = spwm_pkg::TABLE_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// voltage_sample[9:0], battery_sample[19:10], temperature_sample[29:20],
	// switch_level[30], changeover_level[31]
	input  logic [spwm_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// pwm_leg_a[7:0], pwm_leg_b[15:8], dir_a[16], dir_b[17], relay_on[18],
	// buzzer_on[19], alarm_led[20], fan_on[21], fault_code[23:22], powered[24], zeros above
	output logic [spwm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [spwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spwm_pkg::SAMPLE_W-1:0] cfg_data
);
	import spwm_pkg::*;

	localparam int PHASE_W = (TABLE_STEPS > 1) ? $clog2(TABLE_STEPS) : 1;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TABLE_STEPS - 1);

	logic [SCALED_W-1:0] scaled_tab [TABLE_STEPS];

	for (genvar g = 0; g < TABLE_STEPS; g++) begin : g_tab
		localparam int Q = ((g * FULL_POINTS) / TABLE_STEPS) % FULL_POINTS;
		assign scaled_tab[g] = scaled_point(Q);
	end

	logic [SAMPLE_W-1:0] batt_low_q, fan_on_lim_q, fan_off_lim_q, over_temp_q;
	logic [SAMPLE_W-1:0] open_sensor_q, volt_low_q, volt_high_q;

	logic valid_s1;
	logic [SAMPLE_W-1:0] volt_s1, batt_s1, temp_s1;
	logic sw_s1, chg_s1;

	logic [PHASE_W-1:0] phase_q;
	logic half_q;
	logic [AMP_W-1:0] amp_q;
	logic power_q, fault_q, drive_q, relay_q, buzzer_q, led_q, fan_q;
	fault_t kind_q;

	logic [PHASE_W-1:0] phase_d;
	logic half_d;
	logic [AMP_W-1:0] amp_d;
	logic power_d, fault_d, drive_d, relay_d, buzzer_d, led_d, fan_d;
	fault_t kind_d;
	logic [DUTY_W-1:0] leg_a_d, leg_b_d;
	logic dir_a_d, dir_b_d;
	logic [PROD_W-1:0] prod;
	logic [DUTY_W-1:0] duty;

	logic advance;

	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batt_low_q <= 10'd40;
			fan_on_lim_q <= 10'd80;
			fan_off_lim_q <= 10'd100;
			over_temp_q <= 10'd50;
			open_sensor_q <= 10'd200;
			volt_low_q <= 10'd100;
			volt_high_q <= 10'd115;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_BATTERY_LOW: batt_low_q <= cfg_data;
				REG_FAN_ON: fan_on_lim_q <= cfg_data;
				REG_FAN_OFF: fan_off_lim_q <= cfg_data;
				REG_OVER_TEMP: over_temp_q <= cfg_data;
				REG_OPEN_SENSOR: open_sensor_q <= cfg_data;
				REG_VOLT_LOW: volt_low_q <= cfg_data;
				REG_VOLT_HIGH: volt_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			volt_s1 <= s_tdata[9:0];
			batt_s1 <= s_tdata[19:10];
			temp_s1 <= s_tdata[29:20];
			sw_s1 <= s_tdata[30];
			chg_s1 <= s_tdata[31];
		end
	end

	always_comb begin
		power_d = power_q;
		fault_d = fault_q;
		drive_d = drive_q;
		relay_d = relay_q;
		buzzer_d = buzzer_q;
		led_d = led_q;
		fan_d = fan_q;
		kind_d = kind_q;
		amp_d = amp_q;
		leg_a_d = '0;
		leg_b_d = '0;
		dir_a_d = 1'b0;
		dir_b_d = 1'b0;

		if (!sw_s1) begin
			if (!power_q) begin
				if (chg_s1 && !fault_q) begin
					relay_d = 1'b1;
					drive_d = 1'b1;
				end
				power_d = 1'b1;
			end
		end else if (power_q) begin
			drive_d = 1'b0;
			power_d = 1'b0;
			relay_d = 1'b0;
			fault_d = 1'b0;
		end

		if (power_d) begin
			if (batt_s1 <= batt_low_q) begin
				fault_d = 1'b1;
				drive_d = 1'b0;
				relay_d = 1'b0;
				buzzer_d = 1'b0;
				led_d = 1'b0;
				kind_d = FAULT_LOW_BATT;
			end
			if (temp_s1 <= fan_on_lim_q) begin
				fan_d = 1'b1;
			end
			if (temp_s1 > fan_off_lim_q) begin
				fan_d = 1'b0;
			end
			if (temp_s1 <= over_temp_q) begin
				fault_d = 1'b1;
				buzzer_d = 1'b1;
				led_d = 1'b1;
				relay_d = 1'b0;
				fan_d = 1'b1;
				drive_d = 1'b0;
				kind_d = FAULT_TEMP;
			end
			if (temp_s1 >= open_sensor_q) begin
				fault_d = 1'b1;
				buzzer_d = 1'b1;
				led_d = 1'b1;
				relay_d = 1'b0;
				drive_d = 1'b0;
				kind_d = FAULT_TEMP;
			end
		end

		if (phase_q == PHASE_LAST) begin
			phase_d = '0;
			half_d = !half_q;
		end else begin
			phase_d = phase_q + 1'b1;
			half_d = half_q;
		end

		prod = PROD_W'(amp_q) * PROD_W'(scaled_tab[phase_d]);
		duty = prod[RECIP_SHIFT +: DUTY_W];

		if (drive_d) begin
			if (half_d) begin
				leg_a_d = duty;
				dir_a_d = 1'b1;
			end else begin
				leg_b_d = duty;
				dir_b_d = 1'b1;
			end
			if (volt_s1 < volt_low_q) begin
				if (amp_q < AMP_MAX) begin
					amp_d = amp_q + 1'b1;
				end
			end else if (volt_s1 > volt_high_q) begin
				if (amp_q > AMP_MIN) begin
					amp_d = amp_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			half_q <= 1'b0;
			amp_q <= AMP_MAX;
			power_q <= 1'b0;
			fault_q <= 1'b0;
			drive_q <= 1'b0;
			relay_q <= 1'b0;
			buzzer_q <= 1'b0;
			led_q <= 1'b0;
			fan_q <= 1'b0;
			kind_q <= FAULT_NONE;
		end else if (advance) begin
			phase_q <= phase_d;
			half_q <= half_d;
			amp_q <= amp_d;
			power_q <= power_d;
			fault_q <= fault_d;
			drive_q <= drive_d;
			relay_q <= relay_d;
			buzzer_q <= buzzer_d;
			led_q <= led_d;
			fan_q <= fan_d;
			kind_q <= kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {7'd0, power_d, kind_d, fan_d, led_d, buzzer_d, relay_d,
				dir_b_d, dir_a_d, leg_b_d, leg_a_d};
		end
	end

`ifndef SYNTHESIS
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		amp_q >= AMP_MIN && amp_q <= AMP_MAX)
		else $error("Amplitude left its regulation window.");

	a_one_leg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
		else $error("Both low-side enables are set in one beat.");

	a_drive_powered: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q |-> power_q && relay_q)
		else $error("Drive is enabled without power or relay.");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_LAST)
		else $error("Phase index ran past the last table step.");
`endif

endmodule
